### rtl/gab_pkg.sv
package gab_pkg;

  localparam int unsigned PALETTE_ENTRIES = 256;
  localparam int unsigned PAL_AW          = $clog2(PALETTE_ENTRIES);

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 25;
  localparam int unsigned BASE_W     = 30;

  localparam logic [7:0]  TRANSPARENT_INDEX = 8'hff;
  localparam logic [31:0] WHITE             = 32'hffff_ffff;
  localparam logic [12:0] CURX_MAX          = 13'h1fff;
  localparam logic [15:0] CURY_MAX          = 16'hffff;

  localparam logic [12:0] ATLAS_WIDTH_RST = 13'd1024;
  localparam logic [24:0] PIXEL_COUNT_RST = 25'd1048576;
  localparam logic [7:0]  SPACING_RST     = 8'd0;
  localparam logic [7:0]  HEIGHT_RST      = 8'd8;
  localparam logic        COLOR_RST       = 1'b0;

  typedef enum logic [1:0] {
    MODE_PALETTE = 2'd0,
    MODE_GLYPH   = 2'd1,
    MODE_BYTE    = 2'd2,
    MODE_FONT    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_PIXEL    = 2'd0,
    KIND_RECT     = 2'd1,
    KIND_OVERFLOW = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATLAS_WIDTH = 3'd0,
    REG_PIXEL_COUNT = 3'd1,
    REG_SPACING     = 3'd2,
    REG_HEIGHT      = 3'd3,
    REG_COLOR       = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic        pal_wr;
    logic [7:0]  slot;
    logic        pal_ok;
    logic [31:0] color;
    logic        use_pal;
    logic [7:0]  pix;
    logic [23:0] base;
    logic        ovf;
    logic        rect;
    logic [11:0] rx;
    logic [15:0] ry;
    logic [7:0]  rw;
    logic [7:0]  rh;
  } job_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] pixel_address;
    logic [31:0] pixel_color;
    logic [11:0] rect_x;
    logic [15:0] rect_y;
    logic [7:0]  rect_width;
    logic [7:0]  rect_height;
    logic        last;
  } res_t;

endpackage

### rtl/gab_if.sv
interface gab_in_if ();
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  palette_slot;
  logic [31:0] palette_color;
  logic [7:0]  glyph_width;
  logic [7:0]  bitmap_byte;

  modport source (output valid, mode, palette_slot, palette_color, glyph_width, bitmap_byte,
                  input ready);
  modport sink (input valid, mode, palette_slot, palette_color, glyph_width, bitmap_byte,
                output ready);
endinterface

interface gab_out_if ();
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [23:0] pixel_address;
  logic [31:0] pixel_color;
  logic [11:0] rect_x;
  logic [15:0] rect_y;
  logic [7:0]  rect_width;
  logic [7:0]  rect_height;
  logic        last;

  modport source (output valid, kind, pixel_address, pixel_color, rect_x, rect_y, rect_width,
                  rect_height, last, input ready);
  modport sink (input valid, kind, pixel_address, pixel_color, rect_x, rect_y, rect_width,
                rect_height, last, output ready);
endinterface

interface gab_cfg_if import gab_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/gab_ram.sv
module gab_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/gab_queue.sv
module gab_queue import gab_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t head_o
);

  job_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_AW:0]   count_q, count_d;

  assign full_o  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("job queue overrun");

endmodule

### rtl/gab_front.sv
module gab_front import gab_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  gab_in_if.sink    in_i,
  gab_cfg_if.sink   cfg_i,
  input  logic      full_i,
  output logic      push_o,
  output job_t      job_o
);

  logic [12:0] atlas_width_q;
  logic [24:0] pixel_count_q;
  logic [7:0]  spacing_q;
  logic [7:0]  height_q;
  logic        color_q;

  logic [12:0]       cur_x_q, cur_x_d;
  logic [15:0]       cur_y_q, cur_y_d;
  logic [7:0]        cur_w_q, cur_w_d;
  logic [7:0]        row_q, row_d;
  logic [7:0]        col_q, col_d;
  logic              abort_q, abort_d;
  logic              stale_q, stale_d;
  logic [BASE_W-1:0] row_base_q, row_base_d;
  logic [BASE_W-1:0] y_base_q, y_base_d;

  logic        accept;
  mode_e       mode;
  logic        push_req;
  logic        width_write;

  logic [13:0] wrap_sum;
  logic        wrap;
  logic [16:0] y_sum;
  logic [15:0] y_wrap;
  logic [12:0] gx;
  logic [15:0] gy;
  logic        empty;

  logic [12:0] fx;
  logic [15:0] fy;
  logic [7:0]  fw;
  logic [13:0] x_sum;
  logic [12:0] x_next;

  logic [30:0] addr_a;
  logic [31:0] diff;
  logic [8:0]  col8, wlim, mono_end, col_end, span_full;
  logic [3:0]  span;
  logic [7:0]  set_bits, over_bits, ovf_bits, keep;
  logic        any_ovf;
  logic [8:0]  row_n;
  logic        row_done, glyph_done, byte_live;

  logic [16:0]       y_row;
  logic [BASE_W-1:0] mul_row, mul_y;

  assign accept      = in_i.valid && in_i.ready;
  assign in_i.ready  = !full_i && !stale_q;
  assign cfg_i.ready = 1'b1;
  assign mode        = mode_e'(in_i.mode);
  assign width_write = cfg_i.valid && (cfg_i.index == REG_ATLAS_WIDTH);

  assign wrap_sum = {1'b0, cur_x_q} + {6'd0, in_i.glyph_width};
  assign wrap     = (wrap_sum >= {1'b0, atlas_width_q});
  assign y_sum    = {1'b0, cur_y_q} + {9'd0, height_q} + {9'd0, spacing_q};
  assign y_wrap   = y_sum[16] ? CURY_MAX : y_sum[15:0];
  assign gx       = wrap ? '0 : cur_x_q;
  assign gy       = wrap ? y_wrap : cur_y_q;
  assign empty    = (in_i.glyph_width == '0) || (height_q == '0);

  assign fx     = (mode == MODE_GLYPH) ? gx : cur_x_q;
  assign fy     = (mode == MODE_GLYPH) ? gy : cur_y_q;
  assign fw     = (mode == MODE_GLYPH) ? in_i.glyph_width : cur_w_q;
  assign x_sum  = {1'b0, fx} + {6'd0, fw} + {6'd0, spacing_q};
  assign x_next = x_sum[13] ? CURX_MAX : x_sum[12:0];

  assign addr_a    = {1'b0, row_base_q} + {18'd0, cur_x_q} + {23'd0, col_q};
  assign diff      = {7'd0, pixel_count_q} - {1'b0, addr_a};
  assign col8      = {1'b0, col_q} + 9'd8;
  assign wlim      = {1'b0, cur_w_q};
  assign mono_end  = (col8 < wlim) ? col8 : wlim;
  assign span_full = mono_end - {1'b0, col_q};
  assign span      = span_full[3:0];
  assign col_end   = color_q ? ({1'b0, col_q} + 9'd1) : mono_end;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      over_bits[i] = diff[31] || ((diff[31:3] == '0) && (diff[2:0] <= 3'(i)));
      if (color_q) begin
        set_bits[i] = (i == 0) && (in_i.bitmap_byte != TRANSPARENT_INDEX);
      end else begin
        set_bits[i] = in_i.bitmap_byte[7-i] && (4'(i) < span);
      end
    end
  end

  assign ovf_bits = set_bits & over_bits;
  assign any_ovf  = |ovf_bits;

  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < 8; i++) begin
      seen    = seen | ovf_bits[i];
      keep[i] = set_bits[i] & ~seen;
    end
  end

  assign row_n      = {1'b0, row_q} + 9'd1;
  assign row_done   = (col_end >= wlim);
  assign glyph_done = row_done && (row_n >= {1'b0, height_q});
  assign byte_live  = !abort_q && (cur_w_q != '0);

  assign y_row   = {1'b0, cur_y_q} + {9'd0, row_q};
  assign mul_row = {13'd0, y_row} * {17'd0, atlas_width_q};
  assign mul_y   = {14'd0, cur_y_q} * {17'd0, atlas_width_q};

  always_comb begin
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    cur_w_d    = cur_w_q;
    row_d      = row_q;
    col_d      = col_q;
    abort_d    = abort_q;
    stale_d    = stale_q;
    row_base_d = row_base_q;
    y_base_d   = y_base_q;
    push_req   = 1'b0;
    job_o      = '0;

    if (accept) begin
      unique case (mode)
        MODE_PALETTE: begin
          job_o.pal_wr = 1'b1;
          job_o.slot   = in_i.palette_slot;
          job_o.pal_ok = ({1'b0, in_i.palette_slot} < 9'(PALETTE_ENTRIES));
          job_o.color  = in_i.palette_color;
          push_req     = 1'b1;
        end
        MODE_FONT: begin
          abort_d    = 1'b0;
          cur_w_d    = '0;
          row_d      = '0;
          col_d      = '0;
          row_base_d = y_base_q;
        end
        MODE_GLYPH: begin
          if (!abort_q) begin
            cur_x_d    = gx;
            cur_y_d    = gy;
            cur_w_d    = in_i.glyph_width;
            row_d      = '0;
            col_d      = '0;
            row_base_d = y_base_q;
            if (wrap) begin
              stale_d = 1'b1;
            end
            if (empty) begin
              job_o.rect = 1'b1;
              job_o.rx   = fx[11:0];
              job_o.ry   = fy;
              job_o.rw   = fw;
              job_o.rh   = height_q;
              cur_x_d    = x_next;
              cur_w_d    = '0;
              push_req   = 1'b1;
            end
          end
        end
        MODE_BYTE: begin
          if (byte_live) begin
            job_o.pix     = keep;
            job_o.base    = addr_a[23:0];
            job_o.use_pal = color_q;
            job_o.slot    = in_i.bitmap_byte;
            job_o.pal_ok  = ({1'b0, in_i.bitmap_byte} < 9'(PALETTE_ENTRIES));
            job_o.color   = WHITE;
            push_req      = (|keep) || any_ovf;
            if (any_ovf) begin
              job_o.ovf  = 1'b1;
              abort_d    = 1'b1;
              cur_w_d    = '0;
              row_d      = '0;
              col_d      = '0;
              row_base_d = y_base_q;
            end else if (row_done) begin
              col_d = '0;
              if (glyph_done) begin
                job_o.rect = 1'b1;
                job_o.rx   = fx[11:0];
                job_o.ry   = fy;
                job_o.rw   = fw;
                job_o.rh   = height_q;
                cur_x_d    = x_next;
                cur_w_d    = '0;
                row_d      = '0;
                row_base_d = y_base_q;
                push_req   = 1'b1;
              end else begin
                row_d      = row_n[7:0];
                row_base_d = row_base_q + {17'd0, atlas_width_q};
              end
            end else begin
              col_d = col_end[7:0];
            end
          end
        end
        default: ;
      endcase
    end

    if (stale_q) begin
      row_base_d = mul_row;
      y_base_d   = mul_y;
      stale_d    = 1'b0;
    end
    if (width_write) begin
      stale_d = 1'b1;
    end
  end

  assign push_o = push_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_width_q <= ATLAS_WIDTH_RST;
      pixel_count_q <= PIXEL_COUNT_RST;
      spacing_q     <= SPACING_RST;
      height_q      <= HEIGHT_RST;
      color_q       <= COLOR_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_ATLAS_WIDTH: atlas_width_q <= cfg_i.data[12:0];
        REG_PIXEL_COUNT: pixel_count_q <= cfg_i.data[24:0];
        REG_SPACING:     spacing_q     <= cfg_i.data[7:0];
        REG_HEIGHT:      height_q      <= cfg_i.data[7:0];
        REG_COLOR:       color_q       <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q    <= '0;
      cur_y_q    <= '0;
      cur_w_q    <= '0;
      row_q      <= '0;
      col_q      <= '0;
      abort_q    <= 1'b0;
      stale_q    <= 1'b0;
      row_base_q <= '0;
      y_base_q   <= '0;
    end else begin
      cur_x_q    <= cur_x_d;
      cur_y_q    <= cur_y_d;
      cur_w_q    <= cur_w_d;
      row_q      <= row_d;
      col_q      <= col_d;
      abort_q    <= abort_d;
      stale_q    <= stale_d;
      row_base_q <= row_base_d;
      y_base_q   <= y_base_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) (push_o && job_o.ovf) |=> abort_q)
    else $error("overflow beat did not abort the font");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (cur_w_q == '0) |-> (row_base_q == y_base_q) && (row_q == '0))
    else $error("row base out of step with closed glyph");

endmodule

### rtl/gab_back.sv
module gab_back import gab_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  job_t       q_head_i,
  output logic       q_pop_o,
  gab_out_if.source  res_o
);

  job_t        job_q;
  logic        job_v_q;
  logic [7:0]  pix_q;
  res_t        out_q, res_d;
  logic        out_v_q;

  logic        out_free, emit, done, pix_any;
  logic [2:0]  pix_idx;
  logic [7:0]  pix_rest;
  logic [31:0] pal_rdata;
  logic        ram_we, ram_re;

  assign out_free = !out_v_q || res_o.ready;
  assign emit     = job_v_q && out_free;
  assign pix_any  = |pix_q;

  always_comb begin
    pix_idx = '0;
    for (int i = 7; i >= 0; i--) begin
      if (pix_q[i]) begin
        pix_idx = 3'(i);
      end
    end
  end

  assign pix_rest = pix_q & ~(8'd1 << pix_idx);
  assign done     = pix_any ? ((pix_rest == '0) && !job_q.ovf && !job_q.rect) : 1'b1;
  assign q_pop_o  = q_valid_i && (!job_v_q || (emit && done));
  assign ram_we   = q_pop_o && q_head_i.pal_wr && q_head_i.pal_ok;
  assign ram_re   = q_pop_o && !q_head_i.pal_wr && q_head_i.use_pal;

  gab_ram #(
    .Width (32),
    .Depth (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (q_head_i.slot[PAL_AW-1:0]),
    .wdata_i (q_head_i.color),
    .rdata_o (pal_rdata)
  );

  always_comb begin
    res_d      = '0;
    res_d.last = done;
    if (pix_any) begin
      res_d.kind          = KIND_PIXEL;
      res_d.pixel_address = job_q.base + {21'd0, pix_idx};
      res_d.pixel_color   = job_q.use_pal ? (job_q.pal_ok ? pal_rdata : '0) : job_q.color;
    end else if (job_q.ovf) begin
      res_d.kind = KIND_OVERFLOW;
    end else begin
      res_d.kind        = KIND_RECT;
      res_d.rect_x      = job_q.rx;
      res_d.rect_y      = job_q.ry;
      res_d.rect_width  = job_q.rw;
      res_d.rect_height = job_q.rh;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res_d;
    end
    if (q_pop_o && !q_head_i.pal_wr) begin
      job_q <= q_head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      job_v_q <= 1'b0;
      pix_q   <= '0;
    end else begin
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (res_o.ready) begin
        out_v_q <= 1'b0;
      end
      if (q_pop_o) begin
        job_v_q <= !q_head_i.pal_wr;
        pix_q   <= q_head_i.pix;
      end else if (emit) begin
        if (done) begin
          job_v_q <= 1'b0;
        end
        pix_q <= pix_rest;
      end
    end
  end

  assign res_o.valid         = out_v_q;
  assign res_o.kind          = out_q.kind;
  assign res_o.pixel_address = out_q.pixel_address;
  assign res_o.pixel_color   = out_q.pixel_color;
  assign res_o.rect_x        = out_q.rect_x;
  assign res_o.rect_y        = out_q.rect_y;
  assign res_o.rect_width    = out_q.rect_width;
  assign res_o.rect_height   = out_q.rect_height;
  assign res_o.last          = out_q.last;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   job_v_q |-> (pix_q != '0) || job_q.ovf || job_q.rect)
    else $error("job in flight has nothing left to emit");

  assert property (@(posedge clk_i) disable iff (!rst_ni) job_v_q |-> !(job_q.ovf && job_q.rect))
    else $error("aborted glyph carries a rectangle");

endmodule

### rtl/glyph_atlas_blitter.sv
// An item's first result is registered in the job queue, job register and output register.
// Throughput: one item per cycle while in_i.ready is high, one result beat per cycle while
// res_o.ready is high; up to nine beats per item, drained in order by the expansion stage behind
// a four-entry job queue. A glyph start that wraps to a new shelf, or a write of atlas_width,
// holds input ready low while the shelf row base is multiplied out again.
// Reset: cursor, glyph state and config registers to reset values; palette undefined.
module glyph_atlas_blitter import gab_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  gab_in_if.sink     in_i,
  gab_cfg_if.sink    cfg_i,
  gab_out_if.source  res_o
);

  job_t front_job, q_head;
  logic front_push, q_full, q_valid, q_pop;

  gab_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .full_i (q_full),
    .push_o (front_push),
    .job_o  (front_job)
  );

  gab_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .job_i   (front_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  gab_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .res_o     (res_o)
  );

endmodule

### tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gab_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned MAX_PIXELS  = 16777216;

  typedef struct {
    mode_e       mode;
    logic [7:0]  slot;
    logic [31:0] rgba;
    logic [7:0]  width;
    logic [7:0]  bmp;
  } glyph_beat_t;

  class atlas_scoreboard;
    logic [12:0] atlas_w;
    logic [24:0] pixel_cnt;
    logic [7:0]  spacing;
    logic [7:0]  height;
    logic        color_mode;
    logic [12:0] cur_x;
    logic [15:0] cur_y;
    logic [31:0] palette [PALETTE_ENTRIES];
    logic [7:0]  open_w;
    logic [7:0]  row_cnt;
    logic [7:0]  col_cnt;
    logic        aborted;
    res_t        beat_blits[$];
    res_t        queued_blits[$];
    int          errors;
    int          pixels;
    int          rects;
    int          overflows;

    function new();
      atlas_w    = ATLAS_WIDTH_RST;
      pixel_cnt  = PIXEL_COUNT_RST;
      spacing    = SPACING_RST;
      height     = HEIGHT_RST;
      color_mode = COLOR_RST;
      cur_x      = '0;
      cur_y      = '0;
      open_w     = '0;
      row_cnt    = '0;
      col_cnt    = '0;
      aborted    = 1'b0;
      errors     = 0;
      pixels     = 0;
      rects      = 0;
      overflows  = 0;
    endfunction

    function void set_register(cfg_reg_e idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_ATLAS_WIDTH: atlas_w = d[12:0];
        REG_PIXEL_COUNT: pixel_cnt = d[24:0];
        REG_SPACING:     spacing = d[7:0];
        REG_HEIGHT:      height = d[7:0];
        REG_COLOR:       color_mode = d[0];
        default: ;
      endcase
    endfunction

    function void close_glyph(logic [7:0] w);
      res_t        r;
      int unsigned nx;
      r             = '0;
      r.kind        = KIND_RECT;
      r.rect_x      = cur_x[11:0];
      r.rect_y      = cur_y;
      r.rect_width  = w;
      r.rect_height = height;
      beat_blits    = {beat_blits, r};
      nx      = 32'(cur_x) + w + spacing;
      cur_x   = (nx > 32'(CURX_MAX)) ? CURX_MAX : nx[12:0];
      open_w  = '0;
      row_cnt = '0;
      col_cnt = '0;
    endfunction

    function bit put_pixel(int unsigned col, logic [31:0] rgba);
      longint unsigned addr;
      res_t            r;
      addr = (64'(cur_y) + row_cnt) * atlas_w + cur_x + col;
      r    = '0;
      if (addr >= 64'(pixel_cnt)) begin
        r.kind     = KIND_OVERFLOW;
        beat_blits = {beat_blits, r};
        aborted    = 1'b1;
        open_w     = '0;
        row_cnt    = '0;
        col_cnt    = '0;
        return 1'b0;
      end
      r.kind          = KIND_PIXEL;
      r.pixel_address = addr[23:0];
      r.pixel_color   = rgba;
      beat_blits      = {beat_blits, r};
      return 1'b1;
    endfunction

    function void blit_beat(glyph_beat_t b);
      bit          ok;
      int unsigned col;
      int unsigned stop;
      int unsigned x;
      int unsigned ny;
      logic [7:0]  mask;
      beat_blits.delete();
      case (b.mode)
        MODE_PALETTE: palette[b.slot] = b.rgba;
        MODE_FONT: begin
          aborted = 1'b0;
          open_w  = '0;
          row_cnt = '0;
          col_cnt = '0;
        end
        MODE_GLYPH: begin
          if (!aborted) begin
            if (32'(cur_x) + b.width >= 32'(atlas_w)) begin
              ny    = 32'(cur_y) + height + spacing;
              cur_x = '0;
              cur_y = (ny > 32'(CURY_MAX)) ? CURY_MAX : ny[15:0];
            end
            row_cnt = '0;
            col_cnt = '0;
            open_w  = b.width;
            if (b.width == 0 || height == 0) close_glyph(b.width);
          end
        end
        default: begin
          if (!aborted && open_w != 0) begin
            ok  = 1'b1;
            col = col_cnt;
            if (color_mode) begin
              if (b.bmp != TRANSPARENT_INDEX) ok = put_pixel(col, palette[b.bmp]);
              col++;
            end else begin
              mask = 8'h80;
              stop = (col + 8 < open_w) ? col + 8 : open_w;
              for (x = col; x < stop && ok; x++) begin
                if ((b.bmp & mask) != 0) ok = put_pixel(x, WHITE);
                mask >>= 1;
              end
              col = stop;
            end
            if (ok) begin
              if (col >= open_w) begin
                col_cnt = '0;
                row_cnt++;
                if (row_cnt >= height) close_glyph(open_w);
              end else begin
                col_cnt = col[7:0];
              end
            end
          end
        end
      endcase
      if (beat_blits.size() > 0) beat_blits[beat_blits.size()-1].last = 1'b1;
      foreach (beat_blits[i]) begin
        case (beat_blits[i].kind)
          KIND_PIXEL: pixels++;
          KIND_RECT:  rects++;
          default:    overflows++;
        endcase
        queued_blits = {queued_blits, beat_blits[i]};
      end
    endfunction

    function string show(res_t r);
      return $sformatf("kind %0d addr %h color %h rect (%0d,%0d) %0dx%0d last %b", r.kind,
                       r.pixel_address, r.pixel_color, r.rect_x, r.rect_y, r.rect_width,
                       r.rect_height, r.last);
    endfunction

    function void match_blit(res_t got);
      res_t want;
      if (queued_blits.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %s", show(got));
        return;
      end
      want = queued_blits.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch expected: %s", show(want));
          $display("         actual:   %s", show(got));
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  gab_in_if  in_if ();
  gab_cfg_if cfg_if ();
  gab_out_if res_if ();

  glyph_atlas_blitter u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  atlas_scoreboard sb;
  int              idle_mode;
  int              sent;
  int              settings;
  int              quiet;
  bit              slot_used [PALETTE_ENTRIES];
  int              used_slots[$];
  res_t            seen;
  logic [7:0]      mono_rows [8];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit chance(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic logic [7:0] pick_bmp();
    if (!sb.color_mode) return 8'($urandom);
    if (used_slots.size() == 0 || chance(25)) return TRANSPARENT_INDEX;
    return 8'(used_slots[$urandom_range(0, used_slots.size() - 1)]);
  endfunction

  always @(negedge clk_i) begin
    res_if.ready <= !chance((idle_mode == 2) ? 83 : (idle_mode == 3) ? 16 : 0);
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready) begin
      seen = {res_if.kind, res_if.pixel_address, res_if.pixel_color, res_if.rect_x,
              res_if.rect_y, res_if.rect_width, res_if.rect_height, res_if.last};
      sb.match_blit(seen);
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready === 1'b1) || (res_if.valid === 1'b1 && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready === 1'b1))
      quiet = 0;
    else
      quiet = quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no beat for %0d cycles", quiet);
      $display("FAIL glyph_atlas_blitter");
      $finish;
    end
  end

  task automatic send_beat(mode_e m, logic [7:0] slot, logic [31:0] rgba, logic [7:0] w,
                           logic [7:0] bmp);
    glyph_beat_t beat;
    while (chance((idle_mode == 1) ? 83 : (idle_mode == 3) ? 16 : 0)) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.mode          <= m;
    in_if.palette_slot  <= slot;
    in_if.palette_color <= rgba;
    in_if.glyph_width   <= w;
    in_if.bitmap_byte   <= bmp;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    beat.mode  = m;
    beat.slot  = slot;
    beat.rgba  = rgba;
    beat.width = w;
    beat.bmp   = bmp;
    sb.blit_beat(beat);
    if (m == MODE_PALETTE && !slot_used[slot]) begin
      slot_used[slot] = 1'b1;
      used_slots      = {used_slots, int'(slot)};
    end
    sent++;
    @(negedge clk_i);
  endtask

  task automatic send_op(mode_e m, logic [7:0] arg);
    case (m)
      MODE_PALETTE: send_beat(m, arg, $urandom, 8'($urandom_range(0, 254)), pick_bmp());
      MODE_GLYPH:   send_beat(m, 8'($urandom), $urandom, arg, pick_bmp());
      MODE_BYTE:    send_beat(m, 8'($urandom), $urandom, 8'($urandom_range(0, 254)), arg);
      default:      send_beat(m, 8'($urandom), $urandom, 8'($urandom_range(0, 254)),
                              pick_bmp());
    endcase
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (sb.queued_blits.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, int unsigned value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value[CFG_DATA_W-1:0];
    @(posedge clk_i);
    while (cfg_if.ready !== 1'b1) @(posedge clk_i);
    sb.set_register(idx, value[CFG_DATA_W-1:0]);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_setting(int unsigned aw, int unsigned cnt, int unsigned sp,
                               int unsigned ht, int unsigned col);
    wait_drained();
    write_reg(REG_SPACING, sp);
    write_reg(REG_ATLAS_WIDTH, aw);
    write_reg(REG_HEIGHT, ht);
    write_reg(REG_PIXEL_COUNT, cnt);
    write_reg(REG_COLOR, col);
    settings++;
  endtask

  task automatic send_glyph(int wmax, int zero_pct, bit cut_short, int cap);
    int w;
    int total;
    int n;
    w     = chance(zero_pct) ? 0 : $urandom_range(1, wmax);
    total = (sb.color_mode ? w : (w + 7) / 8) * sb.height;
    n     = (cut_short && total > 0) ? $urandom_range(0, total - 1) : total;
    if (n > cap) n = cap;
    send_op(MODE_GLYPH, 8'(w));
    repeat (n) send_op(MODE_BYTE, pick_bmp());
  endtask

  task automatic run_phase(int unsigned aw, int unsigned room, int unsigned sp,
                           int unsigned ht, int unsigned col, int wmax, int zero_pct,
                           int budget, int idle);
    longint unsigned span;
    int unsigned     cnt;
    int              start;
    int              r;
    bit              paused;
    mode_e           m;
    wait_drained();
    span = (64'(sb.cur_y) + room) * aw;
    cnt  = (room == 0) ? 1 : (span > 64'(MAX_PIXELS)) ? MAX_PIXELS : span[31:0];
    apply_setting(aw, cnt, sp, ht, col);
    idle_mode = idle;
    start     = sent;
    paused    = 1'b0;
    while (sent - start < budget) begin
      if (!paused && sent - start >= budget / 2) begin
        paused = 1'b1;
        wait_drained();
      end
      r = $urandom_range(0, 99);
      if (sb.aborted && chance(70)) begin
        send_op(MODE_FONT, 8'($urandom));
      end else if (r < 60) begin
        send_glyph(wmax, zero_pct, 1'b0, budget - (sent - start) - 1);
      end else if (r < 70) begin
        send_glyph(wmax, zero_pct, 1'b1, budget - (sent - start) - 1);
      end else if (r < 76) begin
        send_op(MODE_FONT, 8'($urandom));
      end else if (r < 84) begin
        send_op(MODE_PALETTE, 8'($urandom));
      end else if (r < 92) begin
        send_op(MODE_BYTE, pick_bmp());
      end else begin
        m = mode_e'($urandom_range(0, 3));
        send_op(m, (m == MODE_BYTE) ? pick_bmp() : 8'($urandom_range(0, 254)));
      end
    end
  endtask

  initial begin
    sb                  = new();
    idle_mode           = 0;
    sent                = 0;
    settings            = 1;
    quiet               = 0;
    rst_ni              <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.mode          <= MODE_PALETTE;
    in_if.palette_slot  <= '0;
    in_if.palette_color <= '0;
    in_if.glyph_width   <= '0;
    in_if.bitmap_byte   <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= REG_ATLAS_WIDTH;
    cfg_if.data         <= '0;
    mono_rows           = '{8'h80, 8'h00, 8'hff, 8'h7f, 8'h80, 8'h01, 8'hc0, 8'hff};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: 1024 wide, mono, 8 rows
    send_beat(MODE_PALETTE, 8'h00, 32'h0000_0000, 8'd0, 8'h00);
    send_beat(MODE_PALETTE, 8'hff, 32'hffff_ffff, 8'd254, 8'hff);
    send_beat(MODE_PALETTE, 8'h5a, 32'ha5c3_3c5a, 8'd1, 8'h5a);
    send_beat(MODE_PALETTE, 8'ha5, 32'h5a3c_c3a5, 8'd2, 8'ha5);
    send_op(MODE_BYTE, 8'hff);
    send_op(MODE_GLYPH, 8'd0);
    send_op(MODE_GLYPH, 8'd1);
    foreach (mono_rows[i])
      send_op(MODE_BYTE, mono_rows[i]);
    send_op(MODE_GLYPH, 8'd254);
    send_op(MODE_BYTE, 8'hff);
    send_op(MODE_BYTE, 8'haa);
    send_op(MODE_GLYPH, 8'd9);
    send_op(MODE_BYTE, 8'h55);
    send_op(MODE_FONT, 8'h00);

    // color, second row of the glyph falls past the atlas end
    apply_setting(4096, 4097, 255, 2, 1);
    send_op(MODE_GLYPH, 8'd2);
    send_op(MODE_BYTE, 8'h5a);
    send_op(MODE_BYTE, TRANSPARENT_INDEX);
    send_op(MODE_BYTE, TRANSPARENT_INDEX);
    send_op(MODE_BYTE, 8'ha5);
    send_op(MODE_GLYPH, 8'd3);
    send_op(MODE_BYTE, 8'h00);
    send_beat(MODE_PALETTE, 8'h33, 32'h1234_5678, 8'd7, 8'h33);
    send_op(MODE_FONT, 8'hff);
    send_op(MODE_GLYPH, 8'd1);
    send_op(MODE_BYTE, 8'h33);
    send_op(MODE_BYTE, 8'h00);
    send_op(MODE_FONT, 8'h00);

    run_phase(64, 40, 1, 4, 0, 20, 5, 70, 0);
    run_phase(37, 30, 3, 5, 1, 12, 5, 70, 1);
    run_phase(4096, MAX_PIXELS, 0, 1, 0, 254, 3, 50, 2);
    run_phase(4096, 0, 0, 1, 1, 8, 5, 20, 3);
    run_phase(200, 25, 2, 3, 1, 30, 5, 60, 2);
    run_phase(1, MAX_PIXELS, 255, 255, 0, 2, 90, 180, 3);

    wait_drained();
    repeat (16) @(posedge clk_i);
    $display("covered %0d input beats over %0d register settings, all idle patterns",
             sent, settings);
    $display("checked %0d pixel writes, %0d glyph rectangles, %0d overflows, %0d errors",
             sb.pixels, sb.rects, sb.overflows, sb.errors);
    if (sb.errors == 0 && sb.queued_blits.size() == 0)
      $display("PASS glyph_atlas_blitter");
    else
      $display("FAIL glyph_atlas_blitter");
    $finish;
  end
endmodule

### glyph_atlas_blitter.f
rtl/gab_pkg.sv
rtl/gab_if.sv
rtl/gab_ram.sv
rtl/gab_queue.sv
rtl/gab_front.sv
rtl/gab_back.sv
rtl/glyph_atlas_blitter.sv
tb/sv/tb_top.sv
